// ===== design/tcd_pkg.sv =====
`default_nettype none

package tcd_pkg;

    // Channel count and weak-excursion limit
    localparam int CHANNELS         = 3;
    localparam int WEAK_COUNT_LIMIT = 3;

    // Field widths
    localparam int CH_W    = 2;
    localparam int SMP_W   = 22;
    localparam int ADAPT_W = 7;
    localparam int WEAK_W  = 2;
    localparam int DIFF_W  = SMP_W + 1;
    localparam int WST_W   = ADAPT_W + WEAK_W + 1;
    localparam int CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Baseline filter: b' = (7*b + s) / 8, i.e. b + ((s - b) >>> 3)
    localparam int BASE_SHIFT = 3;

    // Register map
    localparam int NUM_BASE_REGS = 3;
    localparam int REG_IDX_W     = 3;
    localparam int PADDR_W       = REG_IDX_W + 2;
    localparam int PDATA_W       = 32;

    localparam logic [REG_IDX_W-1:0] REG_BASE0  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BASE1  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BASE2  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STRONG = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WEAK   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BAND   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ROUTE  = 3'd7;

    // Register reset values
    localparam logic [SMP_W-1:0]   BASE_RST   = 22'd0;
    localparam logic [SMP_W-1:0]   STRONG_RST = 22'd100;
    localparam logic [SMP_W-1:0]   WEAK_RST   = 22'd30;
    localparam logic [SMP_W-1:0]   BAND_RST   = 22'd20;
    localparam logic [ADAPT_W-1:0] PERIOD_RST = 7'd100;
    localparam logic               ROUTE_RST  = 1'b0;

    typedef logic [CH_AW-1:0]         chan_addr_t;
    typedef logic [SMP_W-1:0]         smp_t;
    typedef logic signed [DIFF_W-1:0] diff_t;

    // Per-channel counters, held in the second state RAM
    typedef struct packed {
        logic [ADAPT_W-1:0] adapt;
        logic [WEAK_W-1:0]  wcnt;
        logic               touched;
    } wstate_t;

    typedef struct packed {
        smp_t               strong_th;
        smp_t               weak_th;
        smp_t               band;
        logic [ADAPT_W-1:0] period;
        logic               route;
    } cfg_t;

    // Baseline load on a write to an initial baseline register
    typedef struct packed {
        logic       valid;
        chan_addr_t ch;
        smp_t       value;
    } base_load_t;

endpackage

`default_nettype wire

// ===== design/tcd_sample_if.sv =====
`default_nettype none

interface tcd_sample_if import tcd_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] channel;
    smp_t            sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

`default_nettype wire

// ===== design/tcd_event_if.sv =====
`default_nettype none

interface tcd_event_if import tcd_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] event_channel;
    logic            pressed;
    logic            to_alternate;

    modport source (output valid, output event_channel, output pressed,
                    output to_alternate, input ready);
    modport sink   (input valid, input event_channel, input pressed,
                    input to_alternate, output ready);
endinterface

`default_nettype wire

// ===== design/tcd_ram.sv =====
`default_nettype none

module tcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/tcd_regs.sv =====
`default_nettype none

module tcd_regs import tcd_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg,
    output base_load_t              bload
);

    smp_t               base_reg [NUM_BASE_REGS];
    smp_t               strong_reg;
    smp_t               weak_reg;
    smp_t               band_reg;
    logic [ADAPT_W-1:0] period_reg;
    logic               route_reg;

    logic                 wr;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BASE_REGS; i++)
            begin
                base_reg[i] <= BASE_RST;
            end
            strong_reg <= STRONG_RST;
            weak_reg   <= WEAK_RST;
            band_reg   <= BAND_RST;
            period_reg <= PERIOD_RST;
            route_reg  <= ROUTE_RST;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_BASE0:  base_reg[0] <= pwdata[SMP_W-1:0];
                REG_BASE1:  base_reg[1] <= pwdata[SMP_W-1:0];
                REG_BASE2:  base_reg[2] <= pwdata[SMP_W-1:0];
                REG_STRONG: strong_reg  <= pwdata[SMP_W-1:0];
                REG_WEAK:   weak_reg    <= pwdata[SMP_W-1:0];
                REG_BAND:   band_reg    <= pwdata[SMP_W-1:0];
                REG_PERIOD: period_reg  <= pwdata[ADAPT_W-1:0];
                REG_ROUTE:  route_reg   <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_BASE0:  prdata = PDATA_W'(base_reg[0]);
            REG_BASE1:  prdata = PDATA_W'(base_reg[1]);
            REG_BASE2:  prdata = PDATA_W'(base_reg[2]);
            REG_STRONG: prdata = PDATA_W'(strong_reg);
            REG_WEAK:   prdata = PDATA_W'(weak_reg);
            REG_BAND:   prdata = PDATA_W'(band_reg);
            REG_PERIOD: prdata = PDATA_W'(period_reg);
            REG_ROUTE:  prdata = PDATA_W'(route_reg);
        endcase
    end

    // Writing an initial baseline also loads that channel's live baseline unless S2 writes back then
    always_comb
    begin
        bload.valid = wr && (32'(idx) < 32'(NUM_BASE_REGS)) && (32'(idx) < 32'(CHANNELS));
        bload.ch    = CH_AW'(idx);
        bload.value = pwdata[SMP_W-1:0];
    end

    always_comb
    begin
        cfg.strong_th = strong_reg;
        cfg.weak_th   = weak_reg;
        cfg.band      = band_reg;
        cfg.period    = period_reg;
        cfg.route     = route_reg;
    end

endmodule

`default_nettype wire

// ===== design/tcd_core.sv =====
`default_nettype none

module tcd_core import tcd_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    tcd_sample_if.sink      smp,
    tcd_event_if.source     evt,
    input  cfg_t            cfg,
    input  base_load_t      bload
);

    // Pipeline control
    logic adv;
    logic acc;
    logic in_rng;

    // S1: state read returns
    logic       s1_valid_reg, s1_valid_next;
    chan_addr_t s1_ch_reg;
    smp_t       s1_smp_reg;

    // Baseline RAM
    logic       b_we;
    chan_addr_t b_waddr;
    smp_t       b_wdata;
    chan_addr_t rd_addr;
    smp_t       b_rdata;
    logic [CHANNELS-1:0] vb_reg;
    logic       b_rvalid_reg;
    smp_t       rd_b;

    // Counter RAM
    logic             w_we;
    logic [WST_W-1:0] w_rdata;
    logic [CHANNELS-1:0] vw_reg;
    logic             w_rvalid_reg;
    wstate_t          rd_w;

    // S2
    logic               s2_valid_reg, s2_valid_next;
    chan_addr_t         s2_ch_reg;
    smp_t               s2_b_reg;
    diff_t              s2_d0_reg;
    logic               s2_chk_reg;
    logic [ADAPT_W-1:0] s2_adapt_reg;
    logic [WEAK_W-1:0]  s2_weak_reg;
    logic               s2_tch_reg;

    // S3
    logic               s3_valid_reg, s3_valid_next;
    chan_addr_t         s3_ch_reg;
    smp_t               s3_b_reg;
    diff_t              s3_diff_reg;
    logic [ADAPT_W-1:0] s3_adapt_reg;
    logic [WEAK_W-1:0]  s3_weak_reg;
    logic               s3_tch_reg;

    // Last counter write, covers the read-during-write case
    logic       wb_valid_reg, wb_valid_next;
    chan_addr_t wb_ch_reg;
    wstate_t    wb_st_reg;

    // Output register
    logic            out_valid_reg, out_valid_next;
    logic [CH_W-1:0] out_ch_reg;
    logic            out_pr_reg;
    logic            out_alt_reg;

    // S1 logic
    logic               s2_hit, s3_hit1, wb_hit1;
    smp_t               b_cur;
    logic [ADAPT_W-1:0] a_cur, a_inc, period_eff, adapt_new;
    logic               chk;
    diff_t              d0;
    wstate_t            w_fwd;

    // S2 logic
    diff_t            q;
    logic [DIFF_W-1:0] mag0;
    logic             upd;
    logic [DIFF_W-1:0] b_sum;
    smp_t             s2_b_new;
    diff_t            diff_new;
    logic             s3_hit2;

    // S3 logic
    logic [DIFF_W-1:0] mag;
    logic              strong_hit, weak_hit;
    logic [WEAK_W-1:0] weak_inc, weak_new;
    logic              cur;
    logic              s3_ev;
    wstate_t           s3_new;

    // ---------------- handshake ----------------
    assign adv       = !(s3_ev && out_valid_reg && !evt.ready);
    assign smp.ready = adv;
    assign in_rng    = (32'(smp.channel) < 32'(CHANNELS));
    assign acc       = smp.valid && adv && in_rng;
    assign rd_addr   = CH_AW'(smp.channel);

    // ---------------- state RAMs ----------------
    always_comb
    begin
        if (adv && s2_valid_reg)
        begin
            b_we    = 1'b1;
            b_waddr = s2_ch_reg;
            b_wdata = s2_b_new;
        end
        else
        begin
            b_we    = bload.valid;
            b_waddr = bload.ch;
            b_wdata = bload.value;
        end
    end

    assign w_we = adv && s3_valid_reg;

    tcd_ram #(.WIDTH(SMP_W), .DEPTH(CHANNELS)) u_base_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .re    (acc),
        .raddr (rd_addr),
        .rdata (b_rdata)
    );

    tcd_ram #(.WIDTH(WST_W), .DEPTH(CHANNELS)) u_cnt_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (s3_ch_reg),
        .wdata (s3_new),
        .re    (acc),
        .raddr (rd_addr),
        .rdata (w_rdata)
    );

    // never-written entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg       <= '0;
            vw_reg       <= '0;
            b_rvalid_reg <= 1'b0;
            w_rvalid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                b_rvalid_reg <= vb_reg[rd_addr];
                w_rvalid_reg <= vw_reg[rd_addr];
            end
            if (b_we)
            begin
                vb_reg[b_waddr] <= 1'b1;
            end
            if (w_we)
            begin
                vw_reg[s3_ch_reg] <= 1'b1;
            end
        end
    end

    assign rd_b = b_rvalid_reg ? b_rdata : '0;
    assign rd_w = w_rvalid_reg ? wstate_t'(w_rdata) : '0;

    // ---------------- S1: forward, count, first difference ----------------
    assign s2_hit  = s2_valid_reg && (s2_ch_reg == s1_ch_reg);
    assign s3_hit1 = s3_valid_reg && (s3_ch_reg == s1_ch_reg);
    assign wb_hit1 = wb_valid_reg && (wb_ch_reg == s1_ch_reg);

    always_comb
    begin
        priority if (s2_hit)
            b_cur = s2_b_new;
        else if (s3_hit1)
            b_cur = s3_b_reg;
        else
            b_cur = rd_b;

        priority if (s2_hit)
            a_cur = s2_adapt_reg;
        else if (s3_hit1)
            a_cur = s3_adapt_reg;
        else if (wb_hit1)
            a_cur = wb_st_reg.adapt;
        else
            a_cur = rd_w.adapt;

        // weak count and touched state of the item one stage ahead land later
        priority if (s3_hit1)
            w_fwd = s3_new;
        else if (wb_hit1)
            w_fwd = wb_st_reg;
        else
            w_fwd = rd_w;
    end

    assign a_inc      = a_cur + ADAPT_W'(1);
    assign period_eff = (cfg.period == '0) ? ADAPT_W'(1) : cfg.period;
    assign chk        = (a_inc >= period_eff);
    assign adapt_new  = chk ? '0 : a_inc;
    assign d0         = $signed({1'b0, s1_smp_reg}) - $signed({1'b0, b_cur});

    // ---------------- S2: baseline adaptation ----------------
    assign q        = s2_d0_reg >>> BASE_SHIFT;
    assign mag0     = s2_d0_reg[DIFF_W-1] ? $unsigned(-s2_d0_reg) : $unsigned(s2_d0_reg);
    assign upd      = s2_chk_reg && (mag0 < {1'b0, cfg.band});
    assign b_sum    = {1'b0, s2_b_reg} + $unsigned(q);
    assign s2_b_new = upd ? b_sum[SMP_W-1:0] : s2_b_reg;
    assign diff_new = upd ? (s2_d0_reg - q) : s2_d0_reg;
    assign s3_hit2  = s3_valid_reg && (s3_ch_reg == s2_ch_reg);

    // ---------------- S3: touch decision ----------------
    assign mag        = s3_diff_reg[DIFF_W-1] ? $unsigned(-s3_diff_reg)
                                              : $unsigned(s3_diff_reg);
    assign strong_hit = (mag > {1'b0, cfg.strong_th});
    assign weak_hit   = (mag > {1'b0, cfg.weak_th});
    assign weak_inc   = s3_weak_reg + WEAK_W'(1);

    always_comb
    begin
        priority if (strong_hit)
        begin
            cur      = 1'b1;
            weak_new = s3_weak_reg;
        end
        else if (weak_hit)
        begin
            if (weak_inc >= WEAK_W'(WEAK_COUNT_LIMIT))
            begin
                cur      = 1'b1;
                weak_new = '0;
            end
            else
            begin
                cur      = 1'b0;
                weak_new = weak_inc;
            end
        end
        else
        begin
            cur      = 1'b0;
            weak_new = '0;
        end
    end

    assign s3_ev          = s3_valid_reg && (cur != s3_tch_reg);
    assign s3_new.adapt   = s3_adapt_reg;
    assign s3_new.wcnt    = weak_new;
    assign s3_new.touched = cur;

    // ---------------- control registers ----------------
    assign s1_valid_next  = adv ? acc : s1_valid_reg;
    assign s2_valid_next  = adv ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next  = adv ? s2_valid_reg : s3_valid_reg;
    assign wb_valid_next  = adv ? s3_valid_reg : wb_valid_reg;
    assign out_valid_next = (adv && s3_ev) ? 1'b1 : (evt.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            wb_valid_reg  <= wb_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ch_reg  <= rd_addr;
            s1_smp_reg <= smp.sample;

            s2_ch_reg    <= s1_ch_reg;
            s2_b_reg     <= b_cur;
            s2_d0_reg    <= d0;
            s2_chk_reg   <= chk;
            s2_adapt_reg <= adapt_new;
            s2_weak_reg  <= w_fwd.wcnt;
            s2_tch_reg   <= w_fwd.touched;

            s3_ch_reg    <= s2_ch_reg;
            s3_b_reg     <= s2_b_new;
            s3_diff_reg  <= diff_new;
            s3_adapt_reg <= s2_adapt_reg;
            s3_weak_reg  <= s3_hit2 ? weak_new : s2_weak_reg;
            s3_tch_reg   <= s3_hit2 ? cur : s2_tch_reg;

            wb_ch_reg <= s3_ch_reg;
            wb_st_reg <= s3_new;
        end
        if (adv && s3_ev)
        begin
            out_ch_reg  <= CH_W'(s3_ch_reg);
            out_pr_reg  <= cur;
            out_alt_reg <= cfg.route;
        end
    end

    assign evt.valid         = out_valid_reg;
    assign evt.event_channel = out_ch_reg;
    assign evt.pressed       = out_pr_reg;
    assign evt.to_alternate  = out_alt_reg;

endmodule

`default_nettype wire

// ===== design/touch_channel_detector.sv =====
// An event beat is offered from the output register after its sample passes S1, S2 and S3.
// Throughput: one sample per cycle; the pipeline holds only when a new event
//   reaches the last stage while the output register is full and not taken.
// Reset: rst_n is asynchronous, active low. Registers return to their reset
//   values; per-entry valid bits make every channel read as zero state at once.
`default_nettype none

module touch_channel_detector import tcd_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    tcd_sample_if.sink              samples,
    tcd_event_if.source             events,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    // Block structure
    //   tcd_regs : APB register file. A write to an initial baseline register
    //              also loads the channel's live baseline in the same cycle unless S2 writes back.
    //   tcd_core : per-channel state in two small RAMs, one read per sample:
    //                baseline RAM  - written back at the end of stage 2
    //                counter RAM   - adapt count, weak count, touched state,
    //                                written back at the end of stage 3
    //              Stages:
    //                S0 accept beat, issue RAM reads
    //                S1 forward in-flight state, bump adapt count, diff = s - b
    //                S2 stable-band check, b + (diff >>> 3), diff against new b
    //                S3 strong/weak thresholds, touched decision, event
    //              Samples for the same channel may come every cycle; younger
    //              items pick up in-flight baseline and counters by forwarding.
    //              Out-of-range channels are dropped at S0.

    cfg_t       cfg;
    base_load_t bload;

    tcd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .bload   (bload)
    );

    tcd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .smp   (samples),
        .evt   (events),
        .cfg   (cfg),
        .bload (bload)
    );

endmodule

`default_nettype wire
